[hw/rtl/lkf_pkg.sv]
`default_nettype none

package lkf_pkg;

  localparam int STATE_DIM = 4;
  localparam int MEAS_DIM  = 2;
  localparam int CTRL_DIM  = 2;
  localparam int DIMX      = 4;
  localparam int ACC_W     = 51;

  typedef logic signed [31:0] word_t;
  typedef logic [7:0]         addr_t;
  typedef logic [3:0]         slot_t;
  typedef logic [2:0]         cnt_t;
  typedef logic [4:0]         pc_t;

  // Slots of the coefficient store. The first nine match the load select codes.
  localparam slot_t SL_A  = 4'd0;
  localparam slot_t SL_B  = 4'd1;
  localparam slot_t SL_Q  = 4'd2;
  localparam slot_t SL_R  = 4'd3;
  localparam slot_t SL_H  = 4'd4;
  localparam slot_t SL_I  = 4'd5;
  localparam slot_t SL_X  = 4'd6;
  localparam slot_t SL_P  = 4'd7;
  localparam slot_t SL_K  = 4'd8;
  localparam slot_t SL_V  = 4'd9;
  localparam slot_t SL_T0 = 4'd10;
  localparam slot_t SL_T1 = 4'd11;
  localparam slot_t SL_T2 = 4'd12;
  localparam slot_t SL_T3 = 4'd13;
  localparam slot_t SL_GL = 4'd14;
  localparam slot_t SL_GR = 4'd15;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_PREDICT = 2'd1;
  localparam logic [1:0] MODE_CORRECT = 2'd2;
  localparam logic [1:0] MODE_READ    = 2'd3;

  localparam word_t Q_ONE    = 32'sd65536;
  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  localparam cnt_t DS = cnt_t'(STATE_DIM);
  localparam cnt_t DM = cnt_t'(MEAS_DIM);
  localparam cnt_t DC = cnt_t'(CTRL_DIM);
  localparam cnt_t D1 = 3'd1;

  localparam pc_t PC_PRED = 5'd0;
  localparam pc_t PC_CORR = 5'd8;

  typedef enum logic [2:0] {
    OP_LOADV, OP_MM, OP_ADD, OP_SUB, OP_COPY, OP_IDENT, OP_INV, OP_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    slot_t    dst;
    slot_t    sa;
    slot_t    sb;
    logic     tb;
    cnt_t     nr;
    cnt_t     nk;
    cnt_t     nc;
  } op_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic [3:0]            sel;
    logic [1:0]            row;
    logic [1:0]            col;
    word_t                 value;
    logic [DIMX-1:0][31:0] vec;
  } cmd_t;

  typedef struct packed {
    logic  re;
    addr_t ra0;
    addr_t ra1;
    logic  we;
    addr_t wa;
    word_t wd;
  } mem_req_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] index;
    word_t      value;
    logic       last;
    logic       singular;
  } emit_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_DISP, ST_LV,
    ST_MM_RD, ST_MM_MUL, ST_MM_ACC, ST_MM_WR,
    ST_EW_RD, ST_EW_WR, ST_ID,
    ST_PS_RD, ST_PS_CMP, ST_PS_END,
    ST_SW_RD, ST_SW_W1, ST_SW_W2,
    ST_PV_RD, ST_PV_LD,
    ST_NM_RD, ST_NM_ST, ST_NM_WT,
    ST_EL_CHK, ST_EL_F, ST_EL_RD, ST_EL_MUL, ST_EL_WR,
    ST_EM_RD, ST_EM_OUT
  } state_t;

  function automatic word_t sat_acc(input logic signed [ACC_W-1:0] v);
    word_t r;
    if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
      r = v[31:0];
    end else begin
      r = v[ACC_W-1] ? WORD_MIN : WORD_MAX;
    end
    return r;
  endfunction

  // Round half up, then floor: exact product plus one half LSB, arithmetic shift.
  function automatic logic signed [47:0] rnd_prod(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t[63:16];
  endfunction

  function automatic logic [31:0] mag(input word_t v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic op_t mk_op(input op_kind_t kind, input slot_t dst, input slot_t sa,
                                input slot_t sb, input logic tb, input cnt_t nr,
                                input cnt_t nk, input cnt_t nc);
    op_t o;
    o.kind = kind;
    o.dst  = dst;
    o.sa   = sa;
    o.sb   = sb;
    o.tb   = tb;
    o.nr   = nr;
    o.nk   = nk;
    o.nc   = nc;
    return o;
  endfunction

  // Operation sequence for predict (from PC_PRED) and correct (from PC_CORR).
  function automatic op_t op_at(input pc_t pc);
    op_t o;
    case (pc)
      5'd0:  o = mk_op(OP_LOADV, SL_V,  SL_V,  SL_V,  1'b0, DS, D1, D1);
      5'd1:  o = mk_op(OP_MM,    SL_T2, SL_A,  SL_X,  1'b0, DS, DS, D1);
      5'd2:  o = mk_op(OP_MM,    SL_T3, SL_B,  SL_V,  1'b0, DS, DC, D1);
      5'd3:  o = mk_op(OP_ADD,   SL_X,  SL_T2, SL_T3, 1'b0, DS, D1, D1);
      5'd4:  o = mk_op(OP_MM,    SL_T0, SL_A,  SL_P,  1'b0, DS, DS, DS);
      5'd5:  o = mk_op(OP_MM,    SL_T1, SL_T0, SL_A,  1'b1, DS, DS, DS);
      5'd6:  o = mk_op(OP_ADD,   SL_P,  SL_T1, SL_Q,  1'b0, DS, D1, DS);
      5'd7:  o = mk_op(OP_END,   SL_V,  SL_V,  SL_V,  1'b0, D1, D1, D1);
      5'd8:  o = mk_op(OP_LOADV, SL_V,  SL_V,  SL_V,  1'b0, DS, D1, D1);
      5'd9:  o = mk_op(OP_MM,    SL_T0, SL_P,  SL_H,  1'b1, DS, DS, DM);
      5'd10: o = mk_op(OP_MM,    SL_T1, SL_H,  SL_T0, 1'b0, DM, DS, DM);
      5'd11: o = mk_op(OP_ADD,   SL_GL, SL_T1, SL_R,  1'b0, DM, D1, DM);
      5'd12: o = mk_op(OP_IDENT, SL_GR, SL_GR, SL_GR, 1'b0, DM, D1, DM);
      5'd13: o = mk_op(OP_INV,   SL_GR, SL_GL, SL_GR, 1'b0, DM, D1, DM);
      5'd14: o = mk_op(OP_MM,    SL_K,  SL_T0, SL_GR, 1'b0, DS, DM, DM);
      5'd15: o = mk_op(OP_MM,    SL_T2, SL_H,  SL_X,  1'b0, DM, DS, D1);
      5'd16: o = mk_op(OP_SUB,   SL_T3, SL_V,  SL_T2, 1'b0, DM, D1, D1);
      5'd17: o = mk_op(OP_MM,    SL_T2, SL_K,  SL_T3, 1'b0, DS, DM, D1);
      5'd18: o = mk_op(OP_ADD,   SL_X,  SL_X,  SL_T2, 1'b0, DS, D1, D1);
      5'd19: o = mk_op(OP_MM,    SL_T0, SL_K,  SL_H,  1'b0, DS, DM, DS);
      5'd20: o = mk_op(OP_SUB,   SL_T1, SL_I,  SL_T0, 1'b0, DS, D1, DS);
      5'd21: o = mk_op(OP_MM,    SL_T0, SL_T1, SL_P,  1'b0, DS, DS, DS);
      5'd22: o = mk_op(OP_COPY,  SL_P,  SL_T0, SL_T0, 1'b0, DS, D1, DS);
      default: o = mk_op(OP_END, SL_V,  SL_V,  SL_V,  1'b0, D1, D1, D1);
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/linear_kalman_filter.sv]
`default_nettype none

// Linear Kalman filter in Q16.16 fixed point, one item at a time. A read-back item
// is held up by output stalls, and a pivot row swap in the inverse adds to a correct.
// The cost is set by the single shared multiply-accumulate, which reads, multiplies
// and accumulates each product and then writes each matrix element, every element
// in turn. The divider adds to this. It normalizes each of the four augmented columns
// at both pivot steps of the inverse, which makes eight divisions. After reset the
// block zeroes all 256 words of its coefficient store before it takes its first
// item. The estimate elements leave through an output register, so the next item
// can be taken while the last element still waits to transfer.
module linear_kalman_filter (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [1:0]             in_mode,
  input  wire  [3:0]             in_matrix_select,
  input  wire  [1:0]             in_row,
  input  wire  [1:0]             in_col,
  input  wire  signed [31:0]     in_value,
  input  wire  signed [31:0]     in_vec0,
  input  wire  signed [31:0]     in_vec1,
  input  wire  signed [31:0]     in_vec2,
  input  wire  signed [31:0]     in_vec3,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [1:0]             out_element_index,
  output logic signed [31:0]     out_element_value,
  output logic                   out_last_element,
  output logic                   out_singular
);
  import lkf_pkg::*;

  cmd_t     cmd_r;
  logic     start_r;
  logic     core_idle;
  mem_req_t mem_req;
  word_t    rd0;
  word_t    rd1;
  logic     div_start;
  word_t    div_num;
  word_t    div_den;
  logic     div_done;
  word_t    div_quo;
  emit_t    emit;
  logic     emit_ready;
  logic     in_fire;

  logic       out_valid_r;
  logic [1:0] out_index_r;
  word_t      out_value_r;
  logic       out_last_r;
  logic       out_sing_r;

  assign in_ready   = core_idle & ~start_r;
  assign in_fire    = in_valid & in_ready;
  assign emit_ready = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= in_fire;
      if (emit.valid && emit_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r.mode   <= in_mode;
      cmd_r.sel    <= in_matrix_select;
      cmd_r.row    <= in_row;
      cmd_r.col    <= in_col;
      cmd_r.value  <= in_value;
      cmd_r.vec[0] <= in_vec0;
      cmd_r.vec[1] <= in_vec1;
      cmd_r.vec[2] <= in_vec2;
      cmd_r.vec[3] <= in_vec3;
    end
    if (emit.valid && emit_ready) begin
      out_index_r <= emit.index;
      out_value_r <= emit.value;
      out_last_r  <= emit.last;
      out_sing_r  <= emit.singular;
    end
  end

  lkf_store u_store (
    .clk (clk),
    .req (mem_req),
    .rd0 (rd0),
    .rd1 (rd1)
  );

  lkf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  lkf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start_r),
    .cmd        (cmd_r),
    .idle       (core_idle),
    .mem_req    (mem_req),
    .rd0        (rd0),
    .rd1        (rd1),
    .div_start  (div_start),
    .div_num    (div_num),
    .div_den    (div_den),
    .div_done   (div_done),
    .div_quo    (div_quo),
    .emit       (emit),
    .emit_ready (emit_ready)
  );

  assign out_valid         = out_valid_r;
  assign out_element_index = out_index_r;
  assign out_element_value = out_value_r;
  assign out_last_element  = out_last_r;
  assign out_singular      = out_sing_r;

endmodule

`default_nettype wire

[hw/rtl/lkf_store.sv]
`default_nettype none

module lkf_store (
  input  wire                clk,
  input  lkf_pkg::mem_req_t  req,
  output lkf_pkg::word_t     rd0,
  output lkf_pkg::word_t     rd1
);
  import lkf_pkg::*;

  word_t mem_r [256];
  word_t rd0_r;
  word_t rd1_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.wa] <= req.wd;
    end
  end

  // Read data holds until the next read so that both words can be used later.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd0_r <= mem_r[req.ra0];
      rd1_r <= mem_r[req.ra1];
    end
  end

  assign rd0 = rd0_r;
  assign rd1 = rd1_r;

endmodule

`default_nettype wire

[hw/rtl/lkf_div.sv]
`default_nettype none

module lkf_div (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  input  lkf_pkg::word_t  num,
  input  lkf_pkg::word_t  den,
  output logic            done,
  output lkf_pkg::word_t  quo
);
  import lkf_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [47:0] dvd_r;
  logic [31:0] dvs_r;
  logic [47:0] quo_r;
  logic        neg_r;

  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        qbit;

  assign rem_sh = {rem_r, dvd_r[47]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign qbit   = ~diff[32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= {mag(num), 16'd0};
      dvs_r <= mag(den);
      quo_r <= '0;
      neg_r <= num[31] ^ den[31];
    end else if (busy_r) begin
      rem_r <= qbit ? diff[31:0] : rem_sh[31:0];
      dvd_r <= {dvd_r[46:0], 1'b0};
      quo_r <= {quo_r[46:0], qbit};
    end
  end

  always_comb begin
    if (!neg_r) begin
      quo = (quo_r > 48'h0000_7FFF_FFFF) ? WORD_MAX : quo_r[31:0];
    end else begin
      quo = (quo_r > 48'h0000_8000_0000) ? WORD_MIN : (32'd0 - quo_r[31:0]);
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

[hw/rtl/lkf_core.sv]
`default_nettype none

module lkf_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  lkf_pkg::cmd_t      cmd,
  output logic               idle,
  output lkf_pkg::mem_req_t  mem_req,
  input  lkf_pkg::word_t     rd0,
  input  lkf_pkg::word_t     rd1,
  output logic               div_start,
  output lkf_pkg::word_t     div_num,
  output lkf_pkg::word_t     div_den,
  input  wire                div_done,
  input  lkf_pkg::word_t     div_quo,
  output lkf_pkg::emit_t     emit,
  input  wire                emit_ready
);
  import lkf_pkg::*;

  localparam cnt_t J_LAST = cnt_t'(2 * MEAS_DIM - 1);
  localparam cnt_t M_LAST = cnt_t'(MEAS_DIM - 1);
  localparam cnt_t S_LAST = cnt_t'(STATE_DIM - 1);
  localparam cnt_t X_LAST = cnt_t'(DIMX - 1);

  state_t state_r, state_nxt;
  pc_t    pc_r, pc_nxt;
  cnt_t   i_r, i_nxt;
  cnt_t   j_r, j_nxt;
  cnt_t   s_r, s_nxt;
  cnt_t   c_r, c_nxt;
  logic [1:0] p_r, p_nxt;
  logic [31:0] best_r, best_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  word_t  f_r, f_nxt;
  word_t  piv_r, piv_nxt;
  logic   sing_r, sing_nxt;
  addr_t  clr_r, clr_nxt;

  op_t    op;
  logic   last_j;
  logic   last_ij;
  logic [31:0] cand;

  // The columns of the augmented matrix [S | inverse] live in two store slots, SL_GL and SL_GR.
  function automatic addr_t aug(input logic [1:0] row, input cnt_t col);
    cnt_t cm;
    cm = col - DM;
    return (col < DM) ? {SL_GL, row, col[1:0]} : {SL_GR, row, cm[1:0]};
  endfunction

  assign op      = op_at(pc_r);
  assign last_j  = (j_r == op.nc - 3'd1);
  assign last_ij = last_j && (i_r == op.nr - 3'd1);
  assign cand    = mag(rd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
      pc_r    <= '0;
      sing_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
      sing_r  <= sing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    s_r    <= s_nxt;
    c_r    <= c_nxt;
    p_r    <= p_nxt;
    best_r <= best_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    f_r    <= f_nxt;
    piv_r  <= piv_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    s_nxt     = s_r;
    c_nxt     = c_r;
    p_nxt     = p_r;
    best_nxt  = best_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    f_nxt     = f_r;
    piv_nxt   = piv_r;
    sing_nxt  = sing_r;
    clr_nxt   = clr_r;
    mem_req   = '0;
    div_start = 1'b0;
    div_num   = rd0;
    div_den   = piv_r;
    emit      = '0;
    idle      = 1'b0;

    case (state_r)
      ST_CLR: begin
        mem_req.we = 1'b1;
        mem_req.wa = clr_r;
        mem_req.wd = '0;
        clr_nxt    = clr_r + 8'd1;
        if (clr_r == 8'hFF) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          sing_nxt = 1'b0;
          case (cmd.mode)
            MODE_LOAD: begin
              mem_req.we = (cmd.sel <= SL_K);
              mem_req.wa = (cmd.sel == SL_X) ? {SL_X, cmd.row, 2'd0}
                                             : {cmd.sel, cmd.row, cmd.col};
              mem_req.wd = cmd.value;
            end
            MODE_PREDICT: begin
              pc_nxt    = PC_PRED;
              state_nxt = ST_DISP;
            end
            MODE_CORRECT: begin
              pc_nxt    = PC_CORR;
              state_nxt = ST_DISP;
            end
            default: begin
              i_nxt     = '0;
              state_nxt = ST_EM_RD;
            end
          endcase
        end
      end

      ST_DISP: begin
        i_nxt   = '0;
        j_nxt   = '0;
        s_nxt   = '0;
        acc_nxt = '0;
        case (op.kind)
          OP_LOADV: state_nxt = ST_LV;
          OP_MM:    state_nxt = ST_MM_RD;
          OP_ADD:   state_nxt = ST_EW_RD;
          OP_SUB:   state_nxt = ST_EW_RD;
          OP_COPY:  state_nxt = ST_EW_RD;
          OP_IDENT: state_nxt = ST_ID;
          OP_INV: begin
            c_nxt     = '0;
            p_nxt     = '0;
            best_nxt  = '0;
            state_nxt = ST_PS_RD;
          end
          default:  state_nxt = ST_EM_RD;
        endcase
      end

      ST_LV: begin
        mem_req.we = 1'b1;
        mem_req.wa = {SL_V, i_r[1:0], 2'd0};
        mem_req.wd = cmd.vec[i_r[1:0]];
        if (i_r == X_LAST) begin
          pc_nxt    = pc_r + 5'd1;
          state_nxt = ST_DISP;
        end else begin
          i_nxt = i_r + 3'd1;
        end
      end

      ST_MM_RD: begin
        mem_req.re  = 1'b1;
        mem_req.ra0 = {op.sa, i_r[1:0], s_r[1:0]};
        mem_req.ra1 = op.tb ? {op.sb, j_r[1:0], s_r[1:0]} : {op.sb, s_r[1:0], j_r[1:0]};
        state_nxt   = ST_MM_MUL;
      end

      ST_MM_MUL: begin
        prod_nxt  = $signed(64'(rd0)) * $signed(64'(rd1));
        state_nxt = ST_MM_ACC;
      end

      ST_MM_ACC: begin
        acc_nxt = acc_r + ACC_W'(rnd_prod(prod_r));
        if (s_r == op.nk - 3'd1) begin
          state_nxt = ST_MM_WR;
        end else begin
          s_nxt     = s_r + 3'd1;
          state_nxt = ST_MM_RD;
        end
      end

      ST_MM_WR: begin
        mem_req.we = 1'b1;
        mem_req.wa = {op.dst, i_r[1:0], j_r[1:0]};
        mem_req.wd = sat_acc(acc_r);
        acc_nxt    = '0;
        s_nxt      = '0;
        j_nxt      = last_j ? '0 : j_r + 3'd1;
        i_nxt      = last_j ? i_r + 3'd1 : i_r;
        if (last_ij) begin
          pc_nxt    = pc_r + 5'd1;
          state_nxt = ST_DISP;
        end else begin
          state_nxt = ST_MM_RD;
        end
      end

      ST_EW_RD: begin
        mem_req.re  = 1'b1;
        mem_req.ra0 = {op.sa, i_r[1:0], j_r[1:0]};
        mem_req.ra1 = {op.sb, i_r[1:0], j_r[1:0]};
        state_nxt   = ST_EW_WR;
      end

      ST_EW_WR: begin
        mem_req.we = 1'b1;
        mem_req.wa = {op.dst, i_r[1:0], j_r[1:0]};
        case (op.kind)
          OP_ADD:  mem_req.wd = sat_acc(ACC_W'(rd0) + ACC_W'(rd1));
          OP_SUB:  mem_req.wd = sat_acc(ACC_W'(rd0) - ACC_W'(rd1));
          default: mem_req.wd = rd0;
        endcase
        j_nxt = last_j ? '0 : j_r + 3'd1;
        i_nxt = last_j ? i_r + 3'd1 : i_r;
        if (last_ij) begin
          pc_nxt    = pc_r + 5'd1;
          state_nxt = ST_DISP;
        end else begin
          state_nxt = ST_EW_RD;
        end
      end

      ST_ID: begin
        mem_req.we = 1'b1;
        mem_req.wa = {op.dst, i_r[1:0], j_r[1:0]};
        mem_req.wd = (i_r == j_r) ? Q_ONE : '0;
        j_nxt      = last_j ? '0 : j_r + 3'd1;
        i_nxt      = last_j ? i_r + 3'd1 : i_r;
        if (last_ij) begin
          pc_nxt    = pc_r + 5'd1;
          state_nxt = ST_DISP;
        end
      end

      // Pivot search over rows c..m-1 of column c; i_r walks the rows.
      ST_PS_RD: begin
        mem_req.re  = 1'b1;
        mem_req.ra0 = aug(i_r[1:0], c_r);
        state_nxt   = ST_PS_CMP;
      end

      ST_PS_CMP: begin
        if (i_r == c_r || cand > best_r) begin
          best_nxt = cand;
          p_nxt    = i_r[1:0];
        end
        if (i_r == M_LAST) begin
          state_nxt = ST_PS_END;
        end else begin
          i_nxt     = i_r + 3'd1;
          state_nxt = ST_PS_RD;
        end
      end

      ST_PS_END: begin
        j_nxt = '0;
        if (best_r == '0) begin
          sing_nxt  = 1'b1;
          i_nxt     = '0;
          state_nxt = ST_EM_RD;
        end else if (p_r != c_r[1:0]) begin
          state_nxt = ST_SW_RD;
        end else begin
          state_nxt = ST_PV_RD;
        end
      end

      ST_SW_RD: begin
        mem_req.re  = 1'b1;
        mem_req.ra0 = aug(p_r, j_r);
        mem_req.ra1 = aug(c_r[1:0], j_r);
        state_nxt   = ST_SW_W1;
      end

      ST_SW_W1: begin
        mem_req.we = 1'b1;
        mem_req.wa = aug(c_r[1:0], j_r);
        mem_req.wd = rd0;
        state_nxt  = ST_SW_W2;
      end

      ST_SW_W2: begin
        mem_req.we = 1'b1;
        mem_req.wa = aug(p_r, j_r);
        mem_req.wd = rd1;
        if (j_r == J_LAST) begin
          state_nxt = ST_PV_RD;
        end else begin
          j_nxt     = j_r + 3'd1;
          state_nxt = ST_SW_RD;
        end
      end

      ST_PV_RD: begin
        mem_req.re  = 1'b1;
        mem_req.ra0 = aug(c_r[1:0], c_r);
        state_nxt   = ST_PV_LD;
      end

      ST_PV_LD: begin
        piv_nxt   = rd0;
        j_nxt     = '0;
        state_nxt = ST_NM_RD;
      end

      ST_NM_RD: begin
        mem_req.re  = 1'b1;
        mem_req.ra0 = aug(c_r[1:0], j_r);
        state_nxt   = ST_NM_ST;
      end

      ST_NM_ST: begin
        div_start = 1'b1;
        state_nxt = ST_NM_WT;
      end

      ST_NM_WT: begin
        if (div_done) begin
          mem_req.we = 1'b1;
          mem_req.wa = aug(c_r[1:0], j_r);
          mem_req.wd = div_quo;
          if (j_r == J_LAST) begin
            i_nxt     = '0;
            state_nxt = ST_EL_CHK;
          end else begin
            j_nxt     = j_r + 3'd1;
            state_nxt = ST_NM_RD;
          end
        end
      end

      // Eliminate column c from every other row; i_r walks the rows.
      ST_EL_CHK: begin
        if (i_r == DM) begin
          if (c_r == M_LAST) begin
            pc_nxt    = pc_r + 5'd1;
            state_nxt = ST_DISP;
          end else begin
            c_nxt     = c_r + 3'd1;
            i_nxt     = c_r + 3'd1;
            best_nxt  = '0;
            state_nxt = ST_PS_RD;
          end
        end else if (i_r == c_r) begin
          i_nxt = i_r + 3'd1;
        end else begin
          mem_req.re  = 1'b1;
          mem_req.ra0 = aug(i_r[1:0], c_r);
          state_nxt   = ST_EL_F;
        end
      end

      ST_EL_F: begin
        f_nxt     = rd0;
        j_nxt     = '0;
        state_nxt = ST_EL_RD;
      end

      ST_EL_RD: begin
        mem_req.re  = 1'b1;
        mem_req.ra0 = aug(i_r[1:0], j_r);
        mem_req.ra1 = aug(c_r[1:0], j_r);
        state_nxt   = ST_EL_MUL;
      end

      ST_EL_MUL: begin
        prod_nxt  = $signed(64'(f_r)) * $signed(64'(rd1));
        state_nxt = ST_EL_WR;
      end

      ST_EL_WR: begin
        mem_req.we = 1'b1;
        mem_req.wa = aug(i_r[1:0], j_r);
        mem_req.wd = sat_acc(ACC_W'(rd0) - ACC_W'(rnd_prod(prod_r)));
        if (j_r == J_LAST) begin
          i_nxt     = i_r + 3'd1;
          state_nxt = ST_EL_CHK;
        end else begin
          j_nxt     = j_r + 3'd1;
          state_nxt = ST_EL_RD;
        end
      end

      ST_EM_RD: begin
        mem_req.re  = 1'b1;
        mem_req.ra0 = {SL_X, i_r[1:0], 2'd0};
        state_nxt   = ST_EM_OUT;
      end

      ST_EM_OUT: begin
        emit.valid    = 1'b1;
        emit.index    = i_r[1:0];
        emit.value    = rd0;
        emit.last     = (i_r == S_LAST);
        emit.singular = sing_r;
        if (emit_ready) begin
          if (i_r == S_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + 3'd1;
            state_nxt = ST_EM_RD;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/lkf_checker.sv]
`default_nettype none

module lkf_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_ready,
  input wire  [1:0]         in_mode,
  input wire  [3:0]         in_matrix_select,
  input wire  [1:0]         in_row,
  input wire  [1:0]         in_col,
  input wire  signed [31:0] in_value,
  input wire  signed [31:0] in_vec0,
  input wire  signed [31:0] in_vec1,
  input wire  signed [31:0] in_vec2,
  input wire  signed [31:0] in_vec3,
  input wire                out_valid,
  input wire                out_ready,
  input wire  [1:0]         out_element_index,
  input wire  signed [31:0] out_element_value,
  input wire                out_last_element,
  input wire                out_singular
);
  import lkf_pkg::*;

  // A stalled result must hold until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element_value)
      && $stable(out_element_index) && $stable(out_singular))
    else $error("result changed while stalled");

  // Only the final estimate element of a run is marked last.
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_element == (out_element_index == 2'(STATE_DIM - 1))))
    else $error("last marker on wrong element");

  // One item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // Reset leaves no result pending.
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind linear_kalman_filter lkf_checker u_lkf_checker (.*);

`default_nettype wire

[dv/linear_kalman_filter_tb.sv]
`timescale 1ns / 1ps

module linear_kalman_filter_tb;
  import lkf_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 320;

  typedef longint mat_t[4][4];
  typedef longint vec_t[4];

  typedef struct packed {
    logic [1:0]       mode;
    logic [3:0]       sel;
    logic [1:0]       row;
    logic [1:0]       col;
    logic [31:0]      value;
    logic [3:0][31:0] vec;
  } item_t;

  typedef struct packed {
    item_t            it;
    logic             typed;
    logic [3:0][31:0] ev;
    logic             es;
  } row_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] value;
    logic        last;
    logic        singular;
  } element_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_mode;
  logic [3:0] in_matrix_select;
  logic [1:0] in_row;
  logic [1:0] in_col;
  logic signed [31:0] in_value;
  logic signed [31:0] in_vec0;
  logic signed [31:0] in_vec1;
  logic signed [31:0] in_vec2;
  logic signed [31:0] in_vec3;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_element_index;
  logic signed [31:0] out_element_value;
  logic out_last_element;
  logic out_singular;

  linear_kalman_filter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_matrix_select(in_matrix_select),
    .in_row(in_row), .in_col(in_col), .in_value(in_value),
    .in_vec0(in_vec0), .in_vec1(in_vec1), .in_vec2(in_vec2), .in_vec3(in_vec3),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_element_index(out_element_index), .out_element_value(out_element_value),
    .out_last_element(out_last_element), .out_singular(out_singular)
  );

  // Filter state as the block should hold it.
  mat_t f_a, f_b, f_q, f_r, f_h, f_i, f_p, f_k;
  vec_t f_x;

  element_t pending_elements[$];
  row_t     directed[$];
  int       errors;
  int       cycles;
  bit       tx_quiet;
  bit       rx_quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint qdiv(longint a, longint b);
    return sat32((a * 64'sd65536) / b);
  endfunction

  function automatic void mat_mul(output mat_t o, input mat_t a, input mat_t b,
                                  input int r, input int k, input int c);
    longint acc;
    foreach (o[i, j]) o[i][j] = 0;
    for (int i = 0; i < r; i++)
      for (int j = 0; j < c; j++) begin
        acc = 0;
        for (int s = 0; s < k; s++) acc += qmul(a[i][s], b[s][j]);
        o[i][j] = sat32(acc);
      end
  endfunction

  function automatic void mat_vec(output vec_t o, input mat_t a, input vec_t x,
                                  input int r, input int k);
    longint acc;
    foreach (o[i]) o[i] = 0;
    for (int i = 0; i < r; i++) begin
      acc = 0;
      for (int s = 0; s < k; s++) acc += qmul(a[i][s], x[s]);
      o[i] = sat32(acc);
    end
  endfunction

  function automatic void transpose(output mat_t o, input mat_t a);
    foreach (a[i, j]) o[j][i] = a[i][j];
  endfunction

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Gauss-Jordan with partial pivoting on the leading m x m block.
  function automatic bit gj_invert(input mat_t s, output mat_t inv, input int m);
    longint g[4][8];
    longint t, piv, f;
    int p;
    foreach (inv[i, j]) inv[i][j] = 0;
    foreach (g[i, j]) g[i][j] = 0;
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < m; j++) g[i][j] = s[i][j];
      g[i][m + i] = 65536;
    end
    for (int c = 0; c < m; c++) begin
      p = c;
      for (int r = c + 1; r < m; r++)
        if (magn(g[r][c]) > magn(g[p][c])) p = r;
      if (g[p][c] == 0) return 1'b0;
      if (p != c)
        for (int j = 0; j < 2 * m; j++) begin
          t = g[p][j]; g[p][j] = g[c][j]; g[c][j] = t;
        end
      piv = g[c][c];
      for (int j = 0; j < 2 * m; j++) g[c][j] = qdiv(g[c][j], piv);
      for (int r = 0; r < m; r++) begin
        if (r != c) begin
          f = g[r][c];
          for (int j = 0; j < 2 * m; j++) g[r][j] = sat32(g[r][j] - qmul(f, g[c][j]));
        end
      end
    end
    for (int i = 0; i < m; i++)
      for (int j = 0; j < m; j++) inv[i][j] = g[i][m + j];
    return 1'b1;
  endfunction

  function automatic void predict_state(input vec_t u);
    vec_t ax, bu;
    mat_t t, at, t2;
    mat_vec(ax, f_a, f_x, STATE_DIM, STATE_DIM);
    mat_vec(bu, f_b, u, STATE_DIM, CTRL_DIM);
    for (int i = 0; i < STATE_DIM; i++) f_x[i] = sat32(ax[i] + bu[i]);
    mat_mul(t, f_a, f_p, STATE_DIM, STATE_DIM, STATE_DIM);
    transpose(at, f_a);
    mat_mul(t2, t, at, STATE_DIM, STATE_DIM, STATE_DIM);
    for (int i = 0; i < STATE_DIM; i++)
      for (int j = 0; j < STATE_DIM; j++) f_p[i][j] = sat32(t2[i][j] + f_q[i][j]);
  endfunction

  function automatic bit correct_state(input vec_t z);
    mat_t ht, ph, s, sinv, kh, kh2, pn;
    vec_t hx, y, ky;
    transpose(ht, f_h);
    mat_mul(ph, f_p, ht, STATE_DIM, STATE_DIM, MEAS_DIM);
    mat_mul(s, f_h, ph, MEAS_DIM, STATE_DIM, MEAS_DIM);
    for (int i = 0; i < MEAS_DIM; i++)
      for (int j = 0; j < MEAS_DIM; j++) s[i][j] = sat32(s[i][j] + f_r[i][j]);
    if (!gj_invert(s, sinv, MEAS_DIM)) return 1'b0;
    mat_mul(f_k, ph, sinv, STATE_DIM, MEAS_DIM, MEAS_DIM);
    mat_vec(hx, f_h, f_x, MEAS_DIM, STATE_DIM);
    foreach (y[i]) y[i] = 0;
    for (int i = 0; i < MEAS_DIM; i++) y[i] = sat32(z[i] - hx[i]);
    mat_vec(ky, f_k, y, STATE_DIM, MEAS_DIM);
    for (int i = 0; i < STATE_DIM; i++) f_x[i] = sat32(f_x[i] + ky[i]);
    mat_mul(kh, f_k, f_h, STATE_DIM, MEAS_DIM, STATE_DIM);
    kh2 = kh;
    for (int i = 0; i < STATE_DIM; i++)
      for (int j = 0; j < STATE_DIM; j++) kh2[i][j] = sat32(f_i[i][j] - kh[i][j]);
    mat_mul(pn, kh2, f_p, STATE_DIM, STATE_DIM, STATE_DIM);
    f_p = pn;
    return 1'b1;
  endfunction

  // Advances the filter state by one transfer and, for any item but a load, queues the estimate it yields.
  function automatic void filter_step(input row_t rw);
    vec_t v;
    bit sing;
    longint val;
    element_t e;
    sing = 1'b0;
    val = longint'(signed'(rw.it.value));
    for (int i = 0; i < 4; i++) v[i] = longint'(signed'(rw.it.vec[i]));
    if (rw.it.mode == MODE_LOAD) begin
      case (rw.it.sel)
        SL_A: f_a[rw.it.row][rw.it.col] = val;
        SL_B: f_b[rw.it.row][rw.it.col] = val;
        SL_Q: f_q[rw.it.row][rw.it.col] = val;
        SL_R: f_r[rw.it.row][rw.it.col] = val;
        SL_H: f_h[rw.it.row][rw.it.col] = val;
        SL_I: f_i[rw.it.row][rw.it.col] = val;
        SL_X: f_x[rw.it.row] = val;
        SL_P: f_p[rw.it.row][rw.it.col] = val;
        SL_K: f_k[rw.it.row][rw.it.col] = val;
        default: ;
      endcase
      return;
    end
    if (rw.it.mode == MODE_PREDICT) predict_state(v);
    else if (rw.it.mode == MODE_CORRECT) sing = !correct_state(v);
    for (int i = 0; i < STATE_DIM; i++) begin
      e.index = i[1:0];
      e.value = rw.typed ? rw.ev[i] : f_x[i][31:0];
      e.last = (i == STATE_DIM - 1);
      e.singular = rw.typed ? rw.es : sing;
      pending_elements.push_back(e);
    end
  endfunction

  function automatic row_t mk_row(input logic [1:0] mode, input logic [3:0] sel,
                                  input logic [1:0] row, input logic [1:0] col,
                                  input logic [31:0] value);
    row_t r;
    r = '0;
    r.it.mode = mode;
    r.it.sel = sel;
    r.it.row = row;
    r.it.col = col;
    r.it.value = value;
    return r;
  endfunction

  task automatic send_item(input row_t rw);
    if (!tx_quiet && $urandom_range(99) < 38) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = rw.it.mode;
    in_matrix_select = rw.it.sel;
    in_row = rw.it.row;
    in_col = rw.it.col;
    in_value = rw.it.value;
    in_vec0 = rw.it.vec[0];
    in_vec1 = rw.it.vec[1];
    in_vec2 = rw.it.vec[2];
    in_vec3 = rw.it.vec[3];
    do @(posedge clk); while (!in_ready);
    filter_step(rw);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [31:0] small_q();
    return 32'($signed($urandom_range(262144)) - 131072);
  endfunction

  always @(negedge clk) begin
    out_ready <= rx_quiet ? 1'b1 : ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    element_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_elements.size() == 0) begin
        $error("unexpected element transfer: index %0d value %0d",
               out_element_index, out_element_value);
        errors++;
      end else begin
        w = pending_elements.pop_front();
        if (out_element_index !== w.index) begin
          $error("element_index: expected %0d, got %0d", w.index, out_element_index);
          errors++;
        end
        if (out_element_value !== w.value) begin
          $error("element_value: expected %0d, got %0d", $signed(w.value),
                 out_element_value);
          errors++;
        end
        if (out_last_element !== w.last) begin
          $error("last_element: expected %0b, got %0b", w.last, out_last_element);
          errors++;
        end
        if (out_singular !== w.singular) begin
          $error("singular: expected %0b, got %0b", w.singular, out_singular);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("linear_kalman_filter_tb failed");
      $finish;
    end
  end

  initial begin
    row_t rw;
    int sent;
    int nload;
    errors = 0;
    cycles = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_READ;
    in_matrix_select = '0;
    in_row = '0;
    in_col = '0;
    in_value = '0;
    in_vec0 = '0;
    in_vec1 = '0;
    in_vec2 = '0;
    in_vec3 = '0;
    out_ready = 1'b0;
    foreach (f_a[i, j]) begin
      f_a[i][j] = 0; f_b[i][j] = 0; f_q[i][j] = 0; f_r[i][j] = 0;
      f_h[i][j] = 0; f_i[i][j] = 0; f_p[i][j] = 0; f_k[i][j] = 0;
    end
    foreach (f_x[i]) f_x[i] = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. After reset everything is zero, so the first rows have
    // known answers; a correct on a zero store hits the singular case.
    rw = mk_row(MODE_READ, SL_A, 2'd0, 2'd0, '0);
    rw.typed = 1'b1;
    directed.push_back(rw);
    rw = mk_row(MODE_CORRECT, SL_A, 2'd0, 2'd0, '0);
    rw.it.vec = {4{32'h7FFF_FFFF}};
    rw.typed = 1'b1;
    rw.es = 1'b1;
    directed.push_back(rw);
    rw = mk_row(MODE_PREDICT, SL_A, 2'd0, 2'd0, '0);
    rw.it.vec = {4{32'h8000_0000}};
    rw.typed = 1'b1;
    directed.push_back(rw);
    // The column of an estimate load is ignored.
    directed.push_back(mk_row(MODE_LOAD, SL_X, 2'd0, 2'd3, WORD_MAX));
    directed.push_back(mk_row(MODE_LOAD, SL_X, 2'd3, 2'd1, WORD_MIN));
    // Out-of-range selects must leave the store alone.
    directed.push_back(mk_row(MODE_LOAD, SL_V, 2'd1, 2'd2, 32'd12345));
    directed.push_back(mk_row(MODE_LOAD, SL_GR, 2'd3, 2'd3, 32'hFFFF_FFFF));
    rw = mk_row(MODE_READ, SL_A, 2'd0, 2'd0, '0);
    rw.typed = 1'b1;
    rw.ev = {WORD_MIN, 32'd0, 32'd0, WORD_MAX};
    directed.push_back(rw);
    directed.push_back(mk_row(MODE_LOAD, SL_A, 2'd0, 2'd0, Q_ONE));
    directed.push_back(mk_row(MODE_LOAD, SL_A, 2'd3, 2'd3, WORD_MAX));
    directed.push_back(mk_row(MODE_LOAD, SL_B, 2'd1, 2'd1, Q_ONE));
    directed.push_back(mk_row(MODE_LOAD, SL_Q, 2'd0, 2'd0, Q_ONE));
    directed.push_back(mk_row(MODE_LOAD, SL_P, 2'd1, 2'd1, Q_ONE));
    rw = mk_row(MODE_PREDICT, SL_A, 2'd0, 2'd0, '0);
    rw.it.vec = {32'h7FFF_FFFF, 32'h8000_0000, -32'sd65536, 32'sd131072};
    directed.push_back(rw);
    directed.push_back(mk_row(MODE_LOAD, SL_H, 2'd0, 2'd0, Q_ONE));
    directed.push_back(mk_row(MODE_LOAD, SL_H, 2'd1, 2'd1, Q_ONE));
    directed.push_back(mk_row(MODE_LOAD, SL_R, 2'd0, 2'd0, Q_ONE));
    directed.push_back(mk_row(MODE_LOAD, SL_R, 2'd1, 2'd1, Q_ONE));
    directed.push_back(mk_row(MODE_LOAD, SL_I, 2'd0, 2'd0, Q_ONE));
    directed.push_back(mk_row(MODE_LOAD, SL_K, 2'd2, 2'd1, WORD_MIN));
    rw = mk_row(MODE_CORRECT, SL_A, 2'd0, 2'd0, '0);
    rw.it.vec = {32'd0, 32'd0, -32'sd200000, 32'sd300000};
    directed.push_back(rw);
    directed.push_back(mk_row(MODE_READ, SL_A, 2'd0, 2'd0, '0));
    foreach (directed[n]) send_item(directed[n]);

    // Random part: mostly episodes of model loads followed by filter steps,
    // with some unconstrained noise mixed in.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_quiet = (sent >= 200 && sent < 260);
      rx_quiet = tx_quiet;
      if (sent >= 150 && sent < 160) begin
        wait (pending_elements.size() == 0);
        @(negedge clk);
      end
      if ($urandom_range(99) < 80) begin
        nload = $urandom_range(2, 8);
        repeat (nload) begin
          rw = mk_row(MODE_LOAD, 4'($urandom_range(8)), 2'($urandom_range(3)),
                      2'($urandom_range(3)), small_q());
          send_item(rw);
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          rw = mk_row(2'($urandom_range(1, 3)), 4'($urandom), 2'($urandom),
                      2'($urandom), 32'($urandom));
          for (int i = 0; i < 4; i++)
            rw.it.vec[i] = ($urandom_range(9) == 0) ? 32'($urandom) : small_q();
          send_item(rw);
          sent++;
        end
      end else begin
        rw = mk_row(2'($urandom), 4'($urandom), 2'($urandom), 2'($urandom),
                    32'($urandom));
        for (int i = 0; i < 4; i++) rw.it.vec[i] = 32'($urandom);
        send_item(rw);
        sent++;
      end
    end
    rx_quiet = 1'b0;

    wait (pending_elements.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_elements.size() == 0) begin
      $display("linear_kalman_filter_tb passed");
    end else begin
      $display("linear_kalman_filter_tb failed");
    end
    $finish;
  end

endmodule
